// File: rtl/core/mcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcl_pkg;

   // register lengths
   localparam int LEN_A = 19;
   localparam int LEN_B = 22;
   localparam int LEN_C = 23;

   // clock bit positions
   localparam int CLK_A = 9;
   localparam int CLK_B = 10;
   localparam int CLK_C = 11;

   // key split
   localparam int KEY_W     = 64;
   localparam int KEY_A_LSB = 45;
   localparam int KEY_B_LSB = 23;

   localparam int PUB_W          = 32;
   localparam int DATA_W         = 8;
   localparam int TAIL_FIRST_BIT = 21;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   typedef struct packed {
      logic              func;
      logic [PUB_W-1:0]  public_word;
      logic [DATA_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_out;
      logic              status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } lfsr_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/core/mcl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mcl_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 114
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/mcl_lfsr.sv
`timescale 1ns / 1ps
`default_nettype none

module mcl_lfsr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mcl_pkg::lfsr_ctrl_type      ctrl,
   input  wire logic [mcl_pkg::KEY_W-1:0]   key,
   output      logic                        ks_bit
);

   logic [mcl_pkg::LEN_A-1:0] a_ff, a_in;
   logic [mcl_pkg::LEN_B-1:0] b_ff, b_in;
   logic [mcl_pkg::LEN_C-1:0] c_ff, c_in;
   logic ca, cb, cc, maj;

   assign ca  = a_ff[mcl_pkg::CLK_A];
   assign cb  = b_ff[mcl_pkg::CLK_B];
   assign cc  = c_ff[mcl_pkg::CLK_C];
   assign maj = (ca & cb) | (ca & cc) | (cb & cc);

   // output taken from the top bits before any shift
   assign ks_bit = a_ff[mcl_pkg::LEN_A-1] ^ b_ff[mcl_pkg::LEN_B-1] ^ c_ff[mcl_pkg::LEN_C-1];

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      if (ctrl.load) begin
         a_in = key[mcl_pkg::KEY_A_LSB +: mcl_pkg::LEN_A];
         b_in = key[mcl_pkg::KEY_B_LSB +: mcl_pkg::LEN_B];
         c_in = key[0 +: mcl_pkg::LEN_C];
      end else if (ctrl.step) begin
         // feedback is clock bit xor top bit
         if (ca == maj) begin
            a_in = {a_ff[mcl_pkg::LEN_A-2:0], ca ^ a_ff[mcl_pkg::LEN_A-1]};
         end
         if (cb == maj) begin
            b_in = {b_ff[mcl_pkg::LEN_B-2:0], cb ^ b_ff[mcl_pkg::LEN_B-1]};
         end
         if (cc == maj) begin
            c_in = {c_ff[mcl_pkg::LEN_C-2:0], cc ^ c_ff[mcl_pkg::LEN_C-1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
         c_ff <= '0;
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/majority_clocked_lfsr_stream_xor.sv
`timescale 1ns / 1ps
`default_nettype none

// Majority-clocked three-register keystream generator that xors one keystream bit
// into bit 0 of each data byte. A block-start request (func 0) reloads the registers
// from the key, runs TOTAL_CLOCKS register clocks, one per cycle, writing the bits from
// clock WARMUP_CLOCKS on into a BLOCK_BITS x 1 keystream RAM, then fills the rest of the
// RAM one entry per cycle with public word bits from bit 21 up (zero above bit 31).
// req_ready stays low until the block start has finished; it gives no response. A data
// request (func 1) goes through the RAM read issued at acceptance, then the response
// register, which waits while a previous response is still held. Once BLOCK_BITS bytes
// are used, or before any block start, bytes pass unchanged with status 1. The key must
// be written through the csr port only while no request is in flight; the block itself
// does not enforce this.
module majority_clocked_lfsr_stream_xor #(
   parameter int BLOCK_BITS    = 114,
   parameter int WARMUP_CLOCKS = 100,
   parameter int TOTAL_CLOCKS  = 192
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire mcl_pkg::req_type          req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      mcl_pkg::rsp_type          rsp_data,
   input  wire logic                      csr_valid,
   output      logic                      csr_ready,
   input  wire logic [mcl_pkg::KEY_W-1:0] csr_data
);

   localparam int IDX_W  = $clog2(BLOCK_BITS);
   localparam int FILL_W = $clog2(BLOCK_BITS + 1);
   localparam int CNT_W  =
      $clog2((TOTAL_CLOCKS > WARMUP_CLOCKS ? TOTAL_CLOCKS : WARMUP_CLOCKS) + 1);
   localparam int POS_W  = $clog2(mcl_pkg::TAIL_FIRST_BIT + BLOCK_BITS + 1);

   localparam logic [CNT_W-1:0]  WARM_C   = CNT_W'(WARMUP_CLOCKS);
   localparam logic [CNT_W-1:0]  LAST_C   = CNT_W'(TOTAL_CLOCKS - 1);
   localparam logic [FILL_W-1:0] FULL_C   = FILL_W'(BLOCK_BITS);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(BLOCK_BITS - 1);
   localparam logic [POS_W-1:0]  POS_LIM  = POS_W'(mcl_pkg::PUB_W);
   localparam logic [POS_W-1:0]  POS_INIT = POS_W'(mcl_pkg::TAIL_FIRST_BIT);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CLOCK = 4'b0010,
      ST_TAIL  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [mcl_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [mcl_pkg::PUB_W-1:0]  pub_ff, pub_in;
   logic [mcl_pkg::DATA_W-1:0] data_ff, data_in;
   logic [CNT_W-1:0]           clk_cnt_ff, clk_cnt_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [IDX_W-1:0]           bit_index_ff, bit_index_in;
   logic                       block_ready_ff, block_ready_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   mcl_pkg::rsp_type           rsp_ff, rsp_in;

   mcl_pkg::lfsr_ctrl_type lfsr_ctrl;
   logic                   ks_bit;
   logic                   req_fire;
   logic                   slot_free;
   logic                   wr_en;
   logic                   wr_data;
   logic                   rd_bit;
   logic                   tail_bit;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign lfsr_ctrl.load = req_fire & (req_data.func == mcl_pkg::FUNC_START);
   assign lfsr_ctrl.step = (state_ff == ST_CLOCK);

   assign tail_bit = (pos_ff < POS_LIM) ? pub_ff[pos_ff[4:0]] : 1'b0;

   always_comb begin
      wr_en   = 1'b0;
      wr_data = 1'b0;
      unique case (state_ff)
         ST_CLOCK: begin
            wr_en   = (clk_cnt_ff >= WARM_C) && (fill_ff < FULL_C);
            wr_data = ks_bit;
         end
         ST_TAIL: begin
            wr_en   = (fill_ff < FULL_C);
            wr_data = tail_bit;
         end
         default: begin
            wr_en   = 1'b0;
            wr_data = 1'b0;
         end
      endcase
   end

   mcl_lfsr u_lfsr (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lfsr_ctrl),
      .key    (key_ff),
      .ks_bit (ks_bit)
   );

   mcl_ram #(
      .WIDTH (1),
      .DEPTH (BLOCK_BITS)
   ) u_ks_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (bit_index_ff),
      .rd_data (rd_bit)
   );

   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      pub_in         = pub_ff;
      data_in        = data_ff;
      clk_cnt_in     = clk_cnt_ff;
      fill_in        = fill_ff;
      pos_in         = pos_ff;
      bit_index_in   = bit_index_ff;
      block_ready_in = block_ready_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_in         = rsp_ff;

      if (csr_valid && csr_ready) begin
         key_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pub_in  = req_data.public_word;
               data_in = req_data.data_in;
               if (req_data.func == mcl_pkg::FUNC_START) begin
                  clk_cnt_in = '0;
                  fill_in    = '0;
                  state_in   = ST_CLOCK;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_CLOCK: begin
            if (wr_en) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            clk_cnt_in = clk_cnt_ff + CNT_W'(1);
            if (clk_cnt_ff == LAST_C) begin
               pos_in   = POS_INIT;
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (wr_en) begin
               fill_in = fill_ff + FILL_W'(1);
               pos_in  = pos_ff + POS_W'(1);
            end else begin
               bit_index_in   = '0;
               block_ready_in = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (block_ready_ff) begin
                  rsp_in.data_out = data_ff ^ {{(mcl_pkg::DATA_W-1){1'b0}}, rd_bit};
                  rsp_in.status   = 1'b0;
                  if (bit_index_ff == LAST_IDX) begin
                     bit_index_in   = '0;
                     block_ready_in = 1'b0;
                  end else begin
                     bit_index_in = bit_index_ff + IDX_W'(1);
                  end
               end else begin
                  // not started or exhausted
                  rsp_in.data_out = data_ff;
                  rsp_in.status   = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         key_ff         <= '0;
         clk_cnt_ff     <= '0;
         fill_ff        <= '0;
         pos_ff         <= '0;
         bit_index_ff   <= '0;
         block_ready_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         key_ff         <= key_in;
         clk_cnt_ff     <= clk_cnt_in;
         fill_ff        <= fill_in;
         pos_ff         <= pos_in;
         bit_index_ff   <= bit_index_in;
         block_ready_ff <= block_ready_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pub_ff  <= pub_in;
      data_ff <= data_in;
      rsp_ff  <= rsp_in;
   end

   a_emit_fills_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && slot_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("data request finished without a response");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (bit_index_ff <= LAST_IDX) && (fill_ff <= FULL_C))
      else $error("keystream index beyond the store");

   a_ready_after_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(block_ready_ff) |-> $past(state_ff == ST_TAIL) && $past(fill_ff == FULL_C))
      else $error("block marked ready before the store was full");

   a_busy_during_start: assert property (@(posedge clock) disable iff (reset)
      lfsr_ctrl.load |=> (state_ff == ST_CLOCK) && !req_ready)
      else $error("block start did not enter the clocking phase");

endmodule

`default_nettype wire

// File: tb/sv/keystream_checker.sv
`timescale 1ns / 1ps

module keystream_checker #(
   parameter int BLOCK_BITS    = 114,
   parameter int WARMUP_CLOCKS = 100,
   parameter int TOTAL_CLOCKS  = 192
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire mcl_pkg::req_type          req_data,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire mcl_pkg::rsp_type          rsp_data,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [mcl_pkg::KEY_W-1:0] csr_data,
   output int                             error_count,
   output int                             outstanding,
   output int                             checked_count,
   output int                             passthru_count
);

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_PASS = 1'b1;

   logic                      ks_bits [BLOCK_BITS];
   int                        ks_ptr;
   logic                      ks_live;
   logic [mcl_pkg::KEY_W-1:0] key_shadow;
   mcl_pkg::rsp_type          bytes_due [$];

   task automatic report(input string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      error_count++;
   endtask

   // reload the three registers, run the majority clocks, then fill the public tail
   task automatic load_block(input logic [mcl_pkg::PUB_W-1:0] pub);
      logic [mcl_pkg::LEN_A-1:0] r19;
      logic [mcl_pkg::LEN_B-1:0] r22;
      logic [mcl_pkg::LEN_C-1:0] r23;
      logic                      ca, cb, cc, maj, ks_out;
      int                        kept, pos;
      r19  = key_shadow[mcl_pkg::KEY_W-1:mcl_pkg::KEY_A_LSB];
      r22  = key_shadow[mcl_pkg::KEY_A_LSB-1:mcl_pkg::KEY_B_LSB];
      r23  = key_shadow[mcl_pkg::KEY_B_LSB-1:0];
      kept = 0;
      for (int i = 0; i < TOTAL_CLOCKS; i++) begin
         ca     = r19[mcl_pkg::CLK_A];
         cb     = r22[mcl_pkg::CLK_B];
         cc     = r23[mcl_pkg::CLK_C];
         maj    = (ca & cb) | (ca & cc) | (cb & cc);
         ks_out = r19[mcl_pkg::LEN_A-1] ^ r22[mcl_pkg::LEN_B-1] ^ r23[mcl_pkg::LEN_C-1];
         // feedback is clock bit xor top bit
         if (ca == maj) r19 = {r19[mcl_pkg::LEN_A-2:0], ca ^ r19[mcl_pkg::LEN_A-1]};
         if (cb == maj) r22 = {r22[mcl_pkg::LEN_B-2:0], cb ^ r22[mcl_pkg::LEN_B-1]};
         if (cc == maj) r23 = {r23[mcl_pkg::LEN_C-2:0], cc ^ r23[mcl_pkg::LEN_C-1]};
         if (i >= WARMUP_CLOCKS) begin
            if (kept < BLOCK_BITS) ks_bits[kept] = ks_out;
            kept++;
         end
      end
      if (kept > BLOCK_BITS) kept = BLOCK_BITS;
      for (int i = kept; i < BLOCK_BITS; i++) begin
         pos        = mcl_pkg::TAIL_FIRST_BIT + (i - kept);
         ks_bits[i] = (pos < mcl_pkg::PUB_W) ? pub[pos] : 1'b0;
      end
      ks_ptr  = 0;
      ks_live = 1'b1;
   endtask

   function automatic mcl_pkg::rsp_type next_cipher_byte(input logic [mcl_pkg::DATA_W-1:0] d);
      mcl_pkg::rsp_type r;
      if (!ks_live) begin
         r.data_out = d;
         r.status   = STATUS_PASS;
      end else begin
         r.data_out = d ^ {{(mcl_pkg::DATA_W-1){1'b0}}, ks_bits[ks_ptr]};
         r.status   = STATUS_OK;
         ks_ptr++;
         if (ks_ptr >= BLOCK_BITS) begin
            ks_ptr  = 0;
            ks_live = 1'b0;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      mcl_pkg::rsp_type want;
      if (reset) begin
         key_shadow     = '0;
         ks_live        = 1'b0;
         ks_ptr         = 0;
         error_count    = 0;
         checked_count  = 0;
         passthru_count = 0;
         bytes_due.delete();
      end else begin
         // a response always belongs to an older request, so compare before pushing
         if (rsp_valid && rsp_ready) begin
            if (bytes_due.size() == 0) begin
               report($sformatf("response with nothing due: data_out=%02h status=%0b",
                                rsp_data.data_out, rsp_data.status));
            end else begin
               want = bytes_due.pop_front();
               if (rsp_data.data_out !== want.data_out)
                  report($sformatf("data_out got %02h want %02h",
                                   rsp_data.data_out, want.data_out));
               if (rsp_data.status !== want.status)
                  report($sformatf("status got %0b want %0b", rsp_data.status, want.status));
               checked_count++;
               if (want.status == STATUS_PASS) passthru_count++;
            end
         end
         if (csr_valid && csr_ready) key_shadow = csr_data;
         if (req_valid && req_ready) begin
            if (req_data.func == mcl_pkg::FUNC_START) load_block(req_data.public_word);
            else bytes_due.push_back(next_cipher_byte(req_data.data_in));
         end
      end
      outstanding <= bytes_due.size();
   end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int LIMIT_CYCLES     = 600000;
   localparam int SETTLE_CYCLES    = 300;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS      = 80;
   localparam int NUM_PHASES       = 6;

   typedef logic [mcl_pkg::DATA_W-1:0] byte_type;
   typedef logic [mcl_pkg::PUB_W-1:0]  pub_type;
   typedef logic [mcl_pkg::KEY_W-1:0]  key_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   mcl_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   mcl_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   key_type          csr_data;

   int error_count, outstanding, checked_count, passthru_count;
   int cycle_count, items_sent, starts_sent, key_writes;
   bit tx_burst;
   bit rx_hold_req;

   majority_clocked_lfsr_stream_xor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   keystream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .error_count    (error_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count),
      .passthru_count (passthru_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timed out after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
   end

   function automatic byte_type rand_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return byte_type'($urandom_range(0, 255));
   endfunction

   function automatic pub_type rand_pub();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return pub_type'($urandom);
   endfunction

   task automatic send_req(input logic f, input pub_type pub, input byte_type d);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{func: f, public_word: pub, data_in: d};
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (f == mcl_pkg::FUNC_START) starts_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
   endtask

   // a block start gives no response, so let a full keystream load pass first
   task automatic write_key(input key_type k);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= k;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      key_writes++;
   endtask

   task automatic run_phase(input int n_items, input bit squeeze);
      int done, seq, len, r;
      done = 0;
      seq  = 0;
      while (done < n_items) begin
         r        = $urandom_range(0, 99);
         tx_burst = ($urandom_range(0, 3) == 0);
         if (r < 80 || (squeeze && seq == 0)) begin
            send_req(mcl_pkg::FUNC_START, rand_pub(), rand_byte());
            done++;
            len = ($urandom_range(0, 1) == 1) ? $urandom_range(108, 124) : $urandom_range(1, 30);
            if (squeeze && seq == 0) begin
               // hold the response side off and keep requesting until the input stalls
               tx_burst    = 1'b1;
               rx_hold_req = 1'b1;
               len         = 40;
            end
            repeat (len) begin
               send_req(mcl_pkg::FUNC_DATA, pub_type'($urandom), rand_byte());
               done++;
            end
            if (squeeze && seq == 0) drain();
            seq++;
         end else if (r < 90) begin
            // stray bytes, often landing after the keystream has run dry
            repeat ($urandom_range(1, 5)) begin
               send_req(mcl_pkg::FUNC_DATA, pub_type'($urandom), rand_byte());
               done++;
            end
         end else begin
            send_req(mcl_pkg::FUNC_START, rand_pub(), rand_byte());
            send_req(mcl_pkg::FUNC_START, rand_pub(), rand_byte());
            done += 2;
         end
      end
   endtask

   initial begin : receiver
      int stall, calm;
      calm = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            stall       = LONG_HOLD_CYCLES;
         end else if (calm > 0) begin
            calm--;
            stall = 0;
         end else begin
            stall = $urandom_range(0, 19);
            if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      key_type phase_keys [NUM_PHASES];
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_valid   <= 1'b0;
      csr_data    <= '0;
      tx_burst    = 1'b0;
      rx_hold_req = 1'b0;
      items_sent  = 0;
      starts_sent = 0;
      key_writes  = 0;
      phase_keys[0] = '0;
      phase_keys[1] = {$urandom, $urandom};
      phase_keys[2] = 64'h8000_0000_0000_0001;
      phase_keys[3] = {$urandom, $urandom};
      phase_keys[4] = '1;
      phase_keys[5] = 64'h5555_AAAA_3C3C_C3C3;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bytes before any block start pass unchanged
      send_req(mcl_pkg::FUNC_DATA, '0, '0);
      send_req(mcl_pkg::FUNC_DATA, '1, '1);
      write_key('1);
      send_req(mcl_pkg::FUNC_START, '0, '1);
      send_req(mcl_pkg::FUNC_DATA, '1, 8'h00);
      send_req(mcl_pkg::FUNC_DATA, '0, 8'hFF);
      send_req(mcl_pkg::FUNC_DATA, pub_type'($urandom), 8'h5A);
      send_req(mcl_pkg::FUNC_DATA, pub_type'($urandom), 8'hA5);
      send_req(mcl_pkg::FUNC_START, '1, '0);
      send_req(mcl_pkg::FUNC_DATA, pub_type'($urandom), 8'hFF);
      send_req(mcl_pkg::FUNC_DATA, pub_type'($urandom), 8'h00);
      send_req(mcl_pkg::FUNC_DATA, pub_type'($urandom), 8'h01);
      send_req(mcl_pkg::FUNC_DATA, pub_type'($urandom), 8'h80);
      // restart mid-block, then two starts back to back
      send_req(mcl_pkg::FUNC_START, 32'h8000_0001, rand_byte());
      send_req(mcl_pkg::FUNC_START, 32'h0020_0000, rand_byte());
      repeat (3) send_req(mcl_pkg::FUNC_DATA, pub_type'($urandom), rand_byte());

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_key(phase_keys[p]);
         run_phase(PHASE_ITEMS, p == 1);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d requests (%0d block starts) under %0d key settings",
               items_sent, starts_sent, key_writes);
      $display("checked %0d responses, %0d of them passed through unkeyed, %0d mismatches",
               checked_count, passthru_count, error_count);
      if (error_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
